FILE: src/bde_pkg.sv
// ----------------------------------------------------------------------------
// bde_pkg
// Shared constants, command codes and cell control types for the bounded
// double-ended queue.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]      count_t;

  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_BACK   = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_CONTAINS   = 3'd4;
  localparam logic [2:0] CMD_REMOVE     = 3'd5;
  localparam logic [2:0] CMD_REVERSE    = 3'd6;
  localparam logic [2:0] CMD_CLEAR      = 3'd7;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHL,
    CELL_SHR
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     valid;
  } cell_ctrl_t;

endpackage

FILE: src/bounded_deque_engine.sv
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue held in a chain of cells. Entries sit in
// physical order from cell 0; a direction mark picks the logical front.
//
//   channel | signals                          | dir
//   --------+----------------------------------+-----
//   in      | in_valid_i/in_ready_o cmd,value  | in
//   out     | out_valid_o/out_ready_i status,  | out
//           | found,front/back,empty,count     |
//
// One item at a time: accept, compare (all cells at once), apply, report,
// then the result is offered on out_valid_o; a new item is accepted only
// after the result is taken and the sequencer is back in idle.
// The compare/apply/report sequencer runs the same way for every command.
// Reset clears count, direction mark and sequencer; cell contents are not
// reset. A stalled result holds all state until out_ready_i.
// ----------------------------------------------------------------------------
module bounded_deque_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             cmd_i,
  input  bde_pkg::value_t        value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output logic                   found_o,
  output bde_pkg::value_t        front_value_o,
  output bde_pkg::value_t        back_value_o,
  output logic                   is_empty_o,
  output bde_pkg::count_t        entry_count_o
);

  localparam int N = bde_pkg::CAPACITY;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_REPORT = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [2:0]      cmd_q;
  bde_pkg::value_t key_q;
  bde_pkg::count_t count_q, count_d;
  logic            rev_q, rev_d;
  logic [1:0]      status_q, status_d;
  logic            found_q, found_d;
  bde_pkg::value_t front_q, back_q;

  bde_pkg::cell_ctrl_t ctrl  [N];
  bde_pkg::value_t     vals  [N];
  bde_pkg::value_t     tails [N];
  logic [N-1:0]        hit;
  logic [N-1:0]        rm_shift;
  logic [N-1:0]        at_slot;
  logic [N:0]          below;
  logic [N:0]          above;

  logic            apply;
  logic            full, empty, any_hit;
  logic            is_push, is_pop;
  logic            push_end, push_start, pop_end, pop_start, do_remove;
  bde_pkg::value_t tail;

  assign apply   = (state_q == S_APPLY);
  assign full    = (count_q == bde_pkg::CNT_W'(N));
  assign empty   = (count_q == '0);
  assign any_hit = |hit;
  assign is_push = (cmd_q == bde_pkg::CMD_PUSH_BACK) || (cmd_q == bde_pkg::CMD_PUSH_FRONT);
  assign is_pop  = (cmd_q == bde_pkg::CMD_POP_BACK) || (cmd_q == bde_pkg::CMD_POP_FRONT);

  assign push_end   = is_push && !full && ((cmd_q == bde_pkg::CMD_PUSH_BACK) != rev_q);
  assign push_start = is_push && !full && ((cmd_q == bde_pkg::CMD_PUSH_BACK) == rev_q);
  assign pop_end    = is_pop && !empty && ((cmd_q == bde_pkg::CMD_POP_BACK) != rev_q);
  assign pop_start  = is_pop && !empty && ((cmd_q == bde_pkg::CMD_POP_BACK) == rev_q);
  assign do_remove  = (cmd_q == bde_pkg::CMD_REMOVE) && any_hit;

  assign below[0] = 1'b0;
  assign above[N] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    bde_pkg::value_t   prev_v, next_v;
    bde_pkg::cell_op_e op_c;

    if (i == 0) begin : g_first
      assign prev_v = key_q;
    end else begin : g_mid
      assign prev_v = vals[i-1];
    end

    if (i == N - 1) begin : g_last
      assign next_v = vals[i];
    end else begin : g_inner
      assign next_v = vals[i+1];
    end

    assign below[i+1]  = below[i] | hit[i];
    assign above[i]    = above[i+1] | hit[i];
    assign rm_shift[i] = rev_q ? ((hit[i] | below[i]) & ~above[i+1]) : (hit[i] | below[i]);
    assign at_slot[i]  = (count_q == bde_pkg::CNT_W'(i));
    assign tails[i]    = (count_q == bde_pkg::CNT_W'(i + 1)) ? vals[i] : '0;

    always_comb begin
      op_c = bde_pkg::CELL_HOLD;
      if (apply) begin
        if (push_end && at_slot[i]) begin
          op_c = bde_pkg::CELL_LOAD;
        end else if (push_start) begin
          op_c = bde_pkg::CELL_SHR;
        end else if (pop_start || (do_remove && rm_shift[i])) begin
          op_c = bde_pkg::CELL_SHL;
        end
      end
    end

    assign ctrl[i] = '{op: op_c, valid: (count_q > bde_pkg::CNT_W'(i))};

    bde_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .prev_i  (prev_v),
      .next_i  (next_v),
      .din_i   (key_q),
      .key_i   (key_q),
      .value_o (vals[i]),
      .hit_o   (hit[i])
    );
  end

  always_comb begin
    tail = '0;
    for (int i = 0; i < N; i++) begin
      tail = tail | tails[i];
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rev_d    = rev_q;
    status_d = status_q;
    found_d  = found_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_MATCH;
      end
      S_MATCH: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        state_d  = S_REPORT;
        status_d = bde_pkg::STATUS_OK;
        found_d  = 1'b0;
        case (cmd_q)
          bde_pkg::CMD_PUSH_BACK, bde_pkg::CMD_PUSH_FRONT: begin
            if (full) status_d = bde_pkg::STATUS_FULL;
            else count_d = count_q + 1'b1;
          end
          bde_pkg::CMD_POP_BACK, bde_pkg::CMD_POP_FRONT: begin
            if (empty) status_d = bde_pkg::STATUS_EMPTY;
            else count_d = count_q - 1'b1;
          end
          bde_pkg::CMD_CONTAINS: begin
            found_d = any_hit;
          end
          bde_pkg::CMD_REMOVE: begin
            found_d = any_hit;
            if (any_hit) count_d = count_q - 1'b1;
          end
          bde_pkg::CMD_REVERSE: begin
            rev_d = ~rev_q;
          end
          default: begin
            count_d = '0;
            rev_d   = 1'b0;
          end
        endcase
      end
      S_REPORT: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rev_q    <= 1'b0;
      status_q <= bde_pkg::STATUS_OK;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rev_q    <= rev_d;
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_i;
      key_q <= value_i;
    end
    if (state_q == S_REPORT) begin
      if (empty) begin
        front_q <= '0;
        back_q  <= '0;
      end else if (rev_q) begin
        front_q <= tail;
        back_q  <= vals[0];
      end else begin
        front_q <= vals[0];
        back_q  <= tail;
      end
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign front_value_o = front_q;
  assign back_value_o  = back_q;
  assign is_empty_o    = empty;
  assign entry_count_o = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bde_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == bde_pkg::STATUS_EMPTY) |-> is_empty_o)
    else $error("empty status with entries held");

  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == bde_pkg::STATUS_FULL) |-> full)
    else $error("full status while not full");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_APPLY) |=> $stable(count_q))
    else $error("count changed outside apply");

endmodule

FILE: src/bde_cell.sv
// ----------------------------------------------------------------------------
// bde_cell
// One storage cell of the queue chain: holds an entry, takes a new value or
// a neighbor's value, and flags a match against the search key.
// ----------------------------------------------------------------------------
module bde_cell (
  input  logic                clk_i,
  input  bde_pkg::cell_ctrl_t ctrl_i,
  input  bde_pkg::value_t     prev_i,
  input  bde_pkg::value_t     next_i,
  input  bde_pkg::value_t     din_i,
  input  bde_pkg::value_t     key_i,
  output bde_pkg::value_t     value_o,
  output logic                hit_o
);

  bde_pkg::value_t value_q;
  bde_pkg::value_t value_d;
  logic            match_q;

  always_comb begin
    case (ctrl_i.op)
      bde_pkg::CELL_LOAD: value_d = din_i;
      bde_pkg::CELL_SHL:  value_d = next_i;
      bde_pkg::CELL_SHR:  value_d = prev_i;
      default:            value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    match_q <= (value_q == key_i);
  end

  assign value_o = value_q;
  assign hit_o   = match_q & ctrl_i.valid;

endmodule

FILE: sim/tb_bounded_deque_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_engine
// Self-checking bench for the bounded deque. Commands go in through the
// valid/ready input channel. A behavioral deque, kept in logical front-to-back
// order, predicts every result. The results are checked field by field as they
// leave the output channel. Directed tests cover the empty, single-entry and
// full corners. Random traffic then runs fill, drain, search and mixed bursts
// under several sender and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_bounded_deque_engine;

  typedef struct packed {
    logic [1:0]      status;
    logic            found;
    bde_pkg::value_t front_value;
    bde_pkg::value_t back_value;
    logic            is_empty;
    bde_pkg::count_t entry_count;
  } deque_result_t;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_SEARCH,
    MODE_MIX
  } traffic_mode_e;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  logic [2:0]      cmd_i       = bde_pkg::CMD_CLEAR;
  bde_pkg::value_t value_i     = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [1:0]      status_o;
  logic            found_o;
  bde_pkg::value_t front_value_o;
  bde_pkg::value_t back_value_o;
  logic            is_empty_o;
  bde_pkg::count_t entry_count_o;

  bde_pkg::value_t deque_model[$];
  deque_result_t   pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int full_pushes    = 0;
  int empty_pops     = 0;
  int removals       = 0;

  bounded_deque_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .is_empty_o    (is_empty_o),
    .entry_count_o (entry_count_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Applies one command to the logical-order deque and returns the result.
  function automatic deque_result_t apply_command(input logic [2:0] cmd,
                                                  input bde_pkg::value_t val);
    deque_result_t   res;
    bde_pkg::value_t flipped[$];
    int              i;
    res = '0;
    res.status = bde_pkg::STATUS_OK;
    case (cmd)
      bde_pkg::CMD_PUSH_BACK, bde_pkg::CMD_PUSH_FRONT: begin
        if (deque_model.size() >= bde_pkg::CAPACITY) begin
          res.status = bde_pkg::STATUS_FULL;
        end else if (cmd == bde_pkg::CMD_PUSH_BACK) begin
          deque_model.push_back(val);
        end else begin
          deque_model.push_front(val);
        end
      end
      bde_pkg::CMD_POP_BACK, bde_pkg::CMD_POP_FRONT: begin
        if (deque_model.size() == 0) begin
          res.status = bde_pkg::STATUS_EMPTY;
        end else if (cmd == bde_pkg::CMD_POP_BACK) begin
          void'(deque_model.pop_back());
        end else begin
          void'(deque_model.pop_front());
        end
      end
      bde_pkg::CMD_CONTAINS: begin
        for (i = 0; i < deque_model.size(); i++) begin
          if (deque_model[i] == val) res.found = 1'b1;
        end
      end
      bde_pkg::CMD_REMOVE: begin
        for (i = 0; i < deque_model.size(); i++) begin
          if (!res.found && deque_model[i] == val) begin
            deque_model.delete(i);
            res.found = 1'b1;
          end
        end
      end
      bde_pkg::CMD_REVERSE: begin
        for (i = 0; i < deque_model.size(); i++) flipped.push_front(deque_model[i]);
        deque_model = flipped;
      end
      default: begin
        deque_model.delete();
      end
    endcase
    if (deque_model.size() > 0) begin
      res.front_value = deque_model[0];
      res.back_value  = deque_model[deque_model.size()-1];
    end
    res.is_empty    = (deque_model.size() == 0);
    res.entry_count = bde_pkg::count_t'(deque_model.size());
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", status_o, '0);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (found_o !== want.found) report_mismatch("found", found_o, want.found);
        if (front_value_o !== want.front_value)
          report_mismatch("front_value", front_value_o, want.front_value);
        if (back_value_o !== want.back_value)
          report_mismatch("back_value", back_value_o, want.back_value);
        if (is_empty_o !== want.is_empty)
          report_mismatch("is_empty", is_empty_o, want.is_empty);
        if (entry_count_o !== want.entry_count)
          report_mismatch("entry_count", entry_count_o, want.entry_count);
      end
    end
  end

  // Valid is only lowered when an idle gap follows, so back-to-back items
  // keep it high.
  task automatic send_item(input logic [2:0] cmd, input bde_pkg::value_t val);
    deque_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    res = apply_command(cmd, val);
    pending_results.push_back(res);
    items_sent++;
    if (res.status == bde_pkg::STATUS_FULL) full_pushes++;
    if (res.status == bde_pkg::STATUS_EMPTY) empty_pops++;
    if (cmd == bde_pkg::CMD_REMOVE && res.found) removals++;
  endtask

  // Nothing pending means valid is already low.
  task automatic drain_results();
    if (pending_results.size() != 0) in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_corners();
    send_item(bde_pkg::CMD_POP_BACK, 32'h1234_5678);
    send_item(bde_pkg::CMD_POP_FRONT, '0);
    send_item(bde_pkg::CMD_CONTAINS, '0);
    send_item(bde_pkg::CMD_REMOVE, '0);
    send_item(bde_pkg::CMD_REVERSE, '1);
    send_item(bde_pkg::CMD_PUSH_BACK, '0);
    send_item(bde_pkg::CMD_REVERSE, '0);
    send_item(bde_pkg::CMD_CONTAINS, '0);
    send_item(bde_pkg::CMD_POP_BACK, '0);
  endtask

  task automatic test_ends_and_remove();
    send_item(bde_pkg::CMD_PUSH_BACK, '1);
    send_item(bde_pkg::CMD_PUSH_FRONT, '0);
    send_item(bde_pkg::CMD_PUSH_BACK, 32'h5);
    send_item(bde_pkg::CMD_REVERSE, '0);
    send_item(bde_pkg::CMD_PUSH_BACK, 32'h1);
    send_item(bde_pkg::CMD_PUSH_FRONT, 32'h2);
    send_item(bde_pkg::CMD_REMOVE, 32'h5);
    send_item(bde_pkg::CMD_REMOVE, 32'h9);
    send_item(bde_pkg::CMD_CONTAINS, '1);
    send_item(bde_pkg::CMD_POP_FRONT, '0);
    send_item(bde_pkg::CMD_POP_BACK, '0);
    send_item(bde_pkg::CMD_CLEAR, '1);
  endtask

  task automatic test_fill_to_capacity();
    int i;
    for (i = 0; i < bde_pkg::CAPACITY; i++) begin
      if (i % 2 == 0) send_item(bde_pkg::CMD_PUSH_BACK, bde_pkg::value_t'(i % 3));
      else send_item(bde_pkg::CMD_PUSH_FRONT, ~bde_pkg::value_t'(i));
    end
    send_item(bde_pkg::CMD_PUSH_BACK, 32'hAAAA_5555);
    send_item(bde_pkg::CMD_PUSH_FRONT, 32'h5555_AAAA);
    send_item(bde_pkg::CMD_REVERSE, '0);
    send_item(bde_pkg::CMD_REMOVE, 32'h1);
    send_item(bde_pkg::CMD_CLEAR, '0);
  endtask

  function automatic bde_pkg::value_t pick_value(input int held_pct);
    int r;
    r = $urandom_range(99);
    if (r < held_pct && deque_model.size() > 0)
      return deque_model[$urandom_range(deque_model.size()-1)];
    if (r < held_pct + 30) return bde_pkg::value_t'($urandom_range(7));
    return bde_pkg::value_t'($urandom);
  endfunction

  function automatic logic [2:0] pick_command(input traffic_mode_e mode);
    int r;
    r = $urandom_range(99);
    if (r < 2) return bde_pkg::CMD_CLEAR;
    if (r < 7) return bde_pkg::CMD_REVERSE;
    case (mode)
      MODE_FILL:
        return (r < 80) ?
               ($urandom_range(1) ? bde_pkg::CMD_PUSH_BACK : bde_pkg::CMD_PUSH_FRONT) :
               logic'($urandom_range(1)) ? bde_pkg::CMD_POP_BACK : bde_pkg::CMD_POP_FRONT;
      MODE_DRAIN:
        return (r < 80) ?
               ($urandom_range(1) ? bde_pkg::CMD_POP_BACK : bde_pkg::CMD_POP_FRONT) :
               logic'($urandom_range(1)) ? bde_pkg::CMD_PUSH_BACK : bde_pkg::CMD_PUSH_FRONT;
      MODE_SEARCH:
        return (r < 70) ?
               ($urandom_range(1) ? bde_pkg::CMD_CONTAINS : bde_pkg::CMD_REMOVE) :
               bde_pkg::CMD_PUSH_BACK;
      default:     return 3'($urandom_range(6));
    endcase
  endfunction

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    traffic_mode_e mode;
    logic [2:0]    cmd;
    int            burst;
    int            i;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    burst = 0;
    mode  = MODE_MIX;
    for (i = 0; i < n; i++) begin
      if (burst == 0) begin
        mode  = traffic_mode_e'($urandom_range(3));
        burst = $urandom_range(20, 6);
      end
      burst--;
      cmd = pick_command(mode);
      if (cmd == bde_pkg::CMD_CONTAINS || cmd == bde_pkg::CMD_REMOVE)
        send_item(cmd, pick_value(60));
      else send_item(cmd, pick_value(15));
      if ($urandom_range(99) < 3) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_corners();
    test_ends_and_remove();
    drain_results();
    test_fill_to_capacity();
    drain_results();
    test_random_traffic(150, 0, 0);
    test_random_traffic(150, 80, 0);
    test_random_traffic(150, 0, 80);
    test_random_traffic(150, 25, 25);
    repeat (20) @(posedge clk_i);
    $display("Ran %0d items, checked %0d results across four stall mixes.",
             items_sent, results_seen);
    $display("Hit %0d full pushes, %0d empty pops and %0d value removals.",
             full_pushes, empty_pops, removals);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/bde_pkg.sv
src/bde_cell.sv
src/bounded_deque_engine.sv
sim/tb_bounded_deque_engine.sv
